// ----- sv/tgi_pkg.sv -----
package tgi_pkg;

	localparam int GRID_X_DEF = 16;
	localparam int GRID_Y_DEF = 16;
	localparam int GRID_Z_DEF = 16;
	localparam int NUM_COMPONENTS_DEF = 3;

	localparam int COORD_W = 32;
	localparam int NODE_W = 16;
	localparam int FRAC_W = 17;
	localparam int FRAC_ONE = 65536;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_Z = 3'd5;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic       valid;
		logic       query;
		logic       comp_ok;
		logic       wr;
		logic [1:0] comp;
	} ctl_t;

	typedef struct packed {
		logic [3:0]               ix;
		logic [3:0]               iy;
		logic [3:0]               iz;
		logic signed [NODE_W-1:0] value;
	} wr_t;

endpackage

// ----- sv/tgi_axis.sv -----
module tgi_axis #(
	parameter int N = tgi_pkg::GRID_X_DEF,
	parameter int IW = $clog2(N)
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [tgi_pkg::COORD_W-1:0] q,
	input  logic signed [tgi_pkg::COORD_W-1:0] org,
	input  logic        [tgi_pkg::COORD_W-1:0] rcp,
	output logic        [IW-1:0]               idx,
	output logic        [tgi_pkg::FRAC_W-1:0]  frac
);

	localparam logic [47:0] LIM = 48'(N - 1) << 16;

	logic signed [tgi_pkg::COORD_W:0] diff;
	logic [tgi_pkg::COORD_W-1:0]      pos_s2;
	logic [63:0]                      prod_s3;
	logic [47:0]                      t;
	logic [47:0]                      tc;
	logic [IW-1:0]                    ihi;

	assign diff = {q[tgi_pkg::COORD_W-1], q} - {org[tgi_pkg::COORD_W-1], org};
	assign t = prod_s3[63:16];
	assign tc = (t > LIM) ? LIM : t;
	assign ihi = tc[16 +: IW];

	always_ff @(posedge clk) begin
		if (en) begin
			// below the origin the coordinate clamps to the first node
			pos_s2 <= (!diff[tgi_pkg::COORD_W] && diff != '0) ?
				diff[tgi_pkg::COORD_W-1:0] : '0;
			prod_s3 <= 64'(pos_s2) * 64'(rcp);
			if (ihi == IW'(N - 1)) begin
				idx <= IW'(N - 2);
				frac <= tgi_pkg::FRAC_W'(tgi_pkg::FRAC_ONE);
			end else begin
				idx <= ihi;
				frac <= {1'b0, tc[15:0]};
			end
		end
	end

endmodule

// ----- sv/tgi_bank.sv -----
module tgi_bank #(
	parameter int DEPTH = 1536,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic                              we,
	input  logic [AW-1:0]                     waddr,
	input  logic signed [tgi_pkg::NODE_W-1:0] wdata,
	input  logic [AW-1:0]                     raddr,
	output logic signed [tgi_pkg::NODE_W-1:0] rdata
);

	logic signed [tgi_pkg::NODE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[waddr] <= wdata;
			end
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/tgi_blend.sv -----
module tgi_blend (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [tgi_pkg::NODE_W-1:0] corner [8],
	input  logic        [tgi_pkg::FRAC_W-1:0] fx,
	input  logic        [tgi_pkg::FRAC_W-1:0] fy,
	input  logic        [tgi_pkg::FRAC_W-1:0] fz,
	output logic signed [tgi_pkg::NODE_W-1:0] r
);

	localparam logic [tgi_pkg::FRAC_W-1:0] ONE = tgi_pkg::FRAC_W'(tgi_pkg::FRAC_ONE);
	localparam logic signed [21:0] SAT_HI = 22'sd32767;
	localparam logic signed [21:0] SAT_LO = -22'sd32768;

	logic signed [33:0] cx_s6 [4];
	logic signed [51:0] cy_s7 [2];
	logic signed [69:0] v_s8;
	logic [tgi_pkg::FRAC_W-1:0] fy_s6;
	logic [tgi_pkg::FRAC_W-1:0] fz_s6;
	logic [tgi_pkg::FRAC_W-1:0] fz_s7;

	logic signed [17:0] wx1, wx0, wy1, wy0, wz1, wz0;
	logic signed [69:0] biased;
	logic signed [21:0] sh;

	assign wx1 = $signed({1'b0, fx});
	assign wx0 = $signed({1'b0, ONE - fx});
	assign wy1 = $signed({1'b0, fy_s6});
	assign wy0 = $signed({1'b0, ONE - fy_s6});
	assign wz1 = $signed({1'b0, fz_s7});
	assign wz0 = $signed({1'b0, ONE - fz_s7});

	// round half up at bit 47, then keep the integer part
	assign biased = v_s8 + (70'sd1 <<< 47);
	assign sh = biased[69:48];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				cx_s6[k] <= 34'(corner[2*k]) * 34'(wx0) + 34'(corner[2*k+1]) * 34'(wx1);
			end
			fy_s6 <= fy;
			fz_s6 <= fz;
			cy_s7[0] <= 52'(cx_s6[0]) * 52'(wy0) + 52'(cx_s6[1]) * 52'(wy1);
			cy_s7[1] <= 52'(cx_s6[2]) * 52'(wy0) + 52'(cx_s6[3]) * 52'(wy1);
			fz_s7 <= fz_s6;
			v_s8 <= 70'(cy_s7[0]) * 70'(wz0) + 70'(cy_s7[1]) * 70'(wz1);
			if (sh > SAT_HI) begin
				r <= SAT_HI[15:0];
			end else if (sh < SAT_LO) begin
				r <= SAT_LO[15:0];
			end else begin
				r <= sh[15:0];
			end
		end
	end

endmodule

// ----- sv/trilinear_grid_interpolator.sv -----
// Trilinear interpolator over a uniform 3-D lattice of Q1.15 node values, one lattice per
// component. A write item (cmd 0) stores one node; a query item (cmd 1) returns one result
// item, the blend of the eight nodes around the point, rounded half up and saturated. Points
// outside the lattice clamp to its faces. The node store is split into eight banks by the
// parity of the node indices, so all eight corners are read in the same cycle: an item
// enters every cycle unless the result is stalled, and its result is offered after the
// axis mapping, bank read and blend stages. A stalled result holds the whole pipeline. A write
// is visible to every query that follows it. Nodes are undefined until written, and the
// origin and reciprocal-spacing registers may only be changed while no item is in flight.
module trilinear_grid_interpolator #(
	parameter int GRID_X = tgi_pkg::GRID_X_DEF,
	parameter int GRID_Y = tgi_pkg::GRID_Y_DEF,
	parameter int GRID_Z = tgi_pkg::GRID_Z_DEF,
	parameter int NUM_COMPONENTS = tgi_pkg::NUM_COMPONENTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [tgi_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tgi_pkg::COORD_W-1:0]          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 cmd,
	input  logic [1:0]                           component,
	input  logic signed [tgi_pkg::COORD_W-1:0]   query_x,
	input  logic signed [tgi_pkg::COORD_W-1:0]   query_y,
	input  logic signed [tgi_pkg::COORD_W-1:0]   query_z,
	input  logic [3:0]                           node_ix,
	input  logic [3:0]                           node_iy,
	input  logic [3:0]                           node_iz,
	input  logic signed [tgi_pkg::NODE_W-1:0]    node_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [tgi_pkg::NODE_W-1:0]    interp_value,
	output logic [1:0]                           result_component
);

	localparam int XW = $clog2(GRID_X);
	localparam int YW = $clog2(GRID_Y);
	localparam int ZW = $clog2(GRID_Z);
	localparam int HX = (GRID_X + 1) / 2;
	localparam int HY = (GRID_Y + 1) / 2;
	localparam int HZ = (GRID_Z + 1) / 2;
	localparam int BANK_DEPTH = NUM_COMPONENTS * HX * HY * HZ;
	localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

	logic signed [tgi_pkg::COORD_W-1:0] origin_q [3];
	logic [tgi_pkg::COORD_W-1:0]        recip_q [3];

	tgi_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8, ctl_s9;
	tgi_pkg::ctl_t ctl_in;
	tgi_pkg::wr_t  wr_s1, wr_s2, wr_s3, wr_s4;

	logic signed [tgi_pkg::COORD_W-1:0] qx_s1, qy_s1, qz_s1;
	logic [XW-1:0] ix_s4;
	logic [YW-1:0] iy_s4;
	logic [ZW-1:0] iz_s4;
	logic [tgi_pkg::FRAC_W-1:0] fx_s4, fy_s4, fz_s4;
	logic [tgi_pkg::FRAC_W-1:0] fx_s5, fy_s5, fz_s5;
	logic [2:0] par_s5;

	logic advance;
	logic [1:0] rd_comp;
	logic [2:0] wbank;
	logic [AW-1:0] waddr;
	logic signed [tgi_pkg::NODE_W-1:0] rdata [8];
	logic signed [tgi_pkg::NODE_W-1:0] corner [8];
	logic signed [tgi_pkg::NODE_W-1:0] r_s9;

	function automatic logic [AW-1:0] bank_addr(input int c, input int hx, input int hy,
			input int hz);
		return AW'(((c * HX + hx) * HY + hy) * HZ + hz);
	endfunction

	assign advance = !(out_valid && out_stall);
	assign in_stall = !advance;

	assign ctl_in.valid = in_valid;
	assign ctl_in.query = (cmd == tgi_pkg::CMD_QUERY);
	assign ctl_in.comp_ok = (int'(component) < NUM_COMPONENTS);
	assign ctl_in.wr = in_valid && (cmd == tgi_pkg::CMD_WRITE) &&
		(int'(component) < NUM_COMPONENTS) && (int'(node_ix) < GRID_X) &&
		(int'(node_iy) < GRID_Y) && (int'(node_iz) < GRID_Z);
	assign ctl_in.comp = component;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				origin_q[a] <= '0;
				recip_q[a] <= tgi_pkg::COORD_W'(tgi_pkg::FRAC_ONE);
			end
		end else if (cfg_write) begin
			case (cfg_index)
				tgi_pkg::REG_ORIGIN_X: origin_q[0] <= cfg_data;
				tgi_pkg::REG_ORIGIN_Y: origin_q[1] <= cfg_data;
				tgi_pkg::REG_ORIGIN_Z: origin_q[2] <= cfg_data;
				tgi_pkg::REG_RECIP_X: recip_q[0] <= cfg_data;
				tgi_pkg::REG_RECIP_Y: recip_q[1] <= cfg_data;
				tgi_pkg::REG_RECIP_Z: recip_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// control travels with the data; hold everything while the result is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
			ctl_s9 <= '0;
		end else if (advance) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
			ctl_s9 <= ctl_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			qx_s1 <= query_x;
			qy_s1 <= query_y;
			qz_s1 <= query_z;
			wr_s1 <= '{ix: node_ix, iy: node_iy, iz: node_iz, value: node_value};
			wr_s2 <= wr_s1;
			wr_s3 <= wr_s2;
			wr_s4 <= wr_s3;
			fx_s5 <= fx_s4;
			fy_s5 <= fy_s4;
			fz_s5 <= fz_s4;
			par_s5 <= {iz_s4[0], iy_s4[0], ix_s4[0]};
		end
	end

	tgi_axis #(.N(GRID_X), .IW(XW)) u_axis_x (
		.clk(clk), .en(advance), .q(qx_s1), .org(origin_q[0]), .rcp(recip_q[0]),
		.idx(ix_s4), .frac(fx_s4)
	);

	tgi_axis #(.N(GRID_Y), .IW(YW)) u_axis_y (
		.clk(clk), .en(advance), .q(qy_s1), .org(origin_q[1]), .rcp(recip_q[1]),
		.idx(iy_s4), .frac(fy_s4)
	);

	tgi_axis #(.N(GRID_Z), .IW(ZW)) u_axis_z (
		.clk(clk), .en(advance), .q(qz_s1), .org(origin_q[2]), .rcp(recip_q[2]),
		.idx(iz_s4), .frac(fz_s4)
	);

	assign rd_comp = ctl_s4.comp_ok ? ctl_s4.comp : 2'd0;
	assign wbank = {wr_s4.iz[0], wr_s4.iy[0], wr_s4.ix[0]};
	assign waddr = bank_addr(int'(ctl_s4.comp), int'(wr_s4.ix >> 1), int'(wr_s4.iy >> 1),
		int'(wr_s4.iz >> 1));

	for (genvar b = 0; b < 8; b++) begin : g_bank
		localparam logic BX = 1'((b >> 0) & 1);
		localparam logic BY = 1'((b >> 1) & 1);
		localparam logic BZ = 1'((b >> 2) & 1);

		logic [XW-1:0] cx;
		logic [YW-1:0] cy;
		logic [ZW-1:0] cz;
		logic [AW-1:0] raddr;

		// the corner that falls in this bank is the lower node or the one above it
		assign cx = ix_s4 + XW'(BX ^ ix_s4[0]);
		assign cy = iy_s4 + YW'(BY ^ iy_s4[0]);
		assign cz = iz_s4 + ZW'(BZ ^ iz_s4[0]);
		assign raddr = bank_addr(int'(rd_comp), int'(cx >> 1), int'(cy >> 1), int'(cz >> 1));

		tgi_bank #(.DEPTH(BANK_DEPTH), .AW(AW)) u_bank (
			.clk(clk),
			.en(advance),
			.we(ctl_s4.wr && (wbank == 3'(b))),
			.waddr(waddr),
			.wdata(wr_s4.value),
			.raddr(raddr),
			.rdata(rdata[b])
		);

		assign corner[b] = rdata[3'(b) ^ par_s5];
	end

	tgi_blend u_blend (
		.clk(clk),
		.en(advance),
		.corner(corner),
		.fx(fx_s5),
		.fy(fy_s5),
		.fz(fz_s5),
		.r(r_s9)
	);

	assign out_valid = ctl_s9.valid && ctl_s9.query;
	assign interp_value = ctl_s9.comp_ok ? r_s9 : '0;
	assign result_component = ctl_s9.comp;

endmodule
